### design/signed_radix_text_converter_assert.svh
// Assertion macros used by the converter's datapath.
// Each use names a label, a condition, a consequence and a message.
`ifndef SIGNED_RADIX_TEXT_CONVERTER_ASSERT_SVH
`define SIGNED_RADIX_TEXT_CONVERTER_ASSERT_SVH

// Check the consequence in the same cycle as the condition.
`define SRTC_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check the consequence in the cycle after the condition.
`define SRTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/srtc_pkg.sv
`default_nettype none

package srtc_pkg;

    localparam int DATA_W     = 32;
    localparam int CHAR_W     = 8;
    localparam int RADIX_W    = 5;
    localparam int SYM_W      = 64;
    localparam int SYM_IDX_W  = 4;
    localparam int ADDR_W     = 5;
    localparam int PDATA_W    = 64;
    localparam int MAX_DIGITS = 32;
    localparam int CNT_W      = 6;
    localparam int STACK_IDX_W = 5;
    localparam int BYTE_IDX_W = 2;

    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_WS_LO = 8'h09;
    localparam logic [CHAR_W-1:0] CH_WS_HI = 8'h0D;

    localparam logic [1:0] REG_RADIX        = 2'd0;
    localparam logic [1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [1:0] REG_SYMBOLS_HIGH = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SIGN,
        ST_EMIT
    } srtc_state_t;

    typedef struct packed {
        logic load;
        logic div;
        logic emit_sign;
        logic emit_digit;
    } srtc_cmd_t;

    typedef struct packed {
        logic div_final;
        logic neg;
        logic last_digit;
        logic out_free;
    } srtc_status_t;

endpackage

`default_nettype wire

### design/srtc_cfg.sv
`default_nettype none

module srtc_cfg #(
    parameter int MAX_RADIX = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [srtc_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [srtc_pkg::PDATA_W-1:0] pwdata,
    output logic      [srtc_pkg::PDATA_W-1:0] prdata,
    output logic      [srtc_pkg::RADIX_W-1:0] radix,
    output logic      [srtc_pkg::SYM_W-1:0]   symbols_low,
    output logic      [srtc_pkg::SYM_W-1:0]   symbols_high,
    output logic                              alpha_ok
);
    import srtc_pkg::*;

    logic [RADIX_W-1:0] radix_reg, radix_next;
    logic [SYM_W-1:0]   sym_low_reg, sym_low_next;
    logic [SYM_W-1:0]   sym_high_reg, sym_high_next;
    logic               alpha_ok_reg, alpha_ok_next;
    logic               wr_en;
    logic [1:0]         reg_idx;

    // Validate the alphabet: range of radix, forbidden bytes, duplicates.
    function automatic logic alpha_check(input logic [RADIX_W-1:0] r,
                                         input logic [2*SYM_W-1:0] s);
        logic             ok;
        logic [CHAR_W-1:0] c;
        ok = (r >= RADIX_W'(2)) && (r <= RADIX_W'(MAX_RADIX));
        for (int i = 0; i < MAX_RADIX; i++) begin
            c = s[i*CHAR_W +: CHAR_W];
            if (RADIX_W'(i) < r) begin
                if (c == '0 || c == CH_PLUS || c == CH_MINUS || c == CH_SPACE ||
                    (c >= CH_WS_LO && c <= CH_WS_HI))
                begin
                    ok = 1'b0;
                end
                for (int j = i + 1; j < MAX_RADIX; j++) begin
                    if (RADIX_W'(j) < r && s[j*CHAR_W +: CHAR_W] == c)
                    begin
                        ok = 1'b0;
                    end
                end
            end
        end
        return ok;
    endfunction

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:3];

    always_comb
    begin
        radix_next    = radix_reg;
        sym_low_next  = sym_low_reg;
        sym_high_next = sym_high_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_RADIX:        radix_next    = pwdata[RADIX_W-1:0];
                REG_SYMBOLS_LOW:  sym_low_next  = pwdata;
                REG_SYMBOLS_HIGH: sym_high_next = pwdata;
                default:          ;
            endcase
        end
        // Judge the alphabet from the values the registers take at this edge.
        alpha_ok_next = alpha_check(radix_next, {sym_high_next, sym_low_next});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg    <= '0;
            sym_low_reg  <= '0;
            sym_high_reg <= '0;
            alpha_ok_reg <= 1'b0;
        end
        else
        begin
            radix_reg    <= radix_next;
            sym_low_reg  <= sym_low_next;
            sym_high_reg <= sym_high_next;
            alpha_ok_reg <= alpha_ok_next;
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_RADIX:        prdata = PDATA_W'(radix_reg);
            REG_SYMBOLS_LOW:  prdata = sym_low_reg;
            REG_SYMBOLS_HIGH: prdata = sym_high_reg;
            default:          prdata = '0;
        endcase
    end

    assign radix        = radix_reg;
    assign symbols_low  = sym_low_reg;
    assign symbols_high = sym_high_reg;
    assign alpha_ok     = alpha_ok_reg;

endmodule

`default_nettype wire

### design/srtc_ctrl.sv
`default_nettype none

module srtc_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic                  alpha_ok,
    input  wire srtc_pkg::srtc_status_t status,
    output srtc_pkg::srtc_cmd_t        cmd
);
    import srtc_pkg::*;

    srtc_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                // Drop the item when the alphabet is invalid.
                if (s_tvalid && alpha_ok)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div = 1'b1;
                if (status.div_final)
                begin
                    state_next = status.neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (status.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (status.last_digit)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/srtc_dp.sv
`default_nettype none
`include "signed_radix_text_converter_assert.svh"

module srtc_dp #(
    parameter int MAX_RADIX = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire srtc_pkg::srtc_cmd_t           cmd,
    output srtc_pkg::srtc_status_t             status,
    input  wire logic [srtc_pkg::DATA_W-1:0]   value,
    input  wire logic [srtc_pkg::RADIX_W-1:0]  radix,
    input  wire logic [srtc_pkg::SYM_W-1:0]    symbols_low,
    input  wire logic [srtc_pkg::SYM_W-1:0]    symbols_high,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [srtc_pkg::CHAR_W-1:0]   m_tdata,
    output logic                               m_tlast
);
    import srtc_pkg::*;

    localparam int DIGIT_W = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
    localparam int NBYTES  = DATA_W / 8;

    logic [DATA_W-1:0]      mag_reg, mag_next;
    logic [DIGIT_W-1:0]     rem_reg, rem_next;
    logic [BYTE_IDX_W-1:0]  byte_reg, byte_next;
    logic                   neg_reg, neg_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [DIGIT_W-1:0]     stack_reg [MAX_DIGITS];
    logic                   out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]      out_data_reg, out_data_next;
    logic                   out_last_reg, out_last_next;

    logic [DATA_W-1:0]      abs_val;
    logic [7:0]             div_byte;
    logic [7:0]             quo_byte;
    logic [RADIX_W-1:0]     part_rem;
    logic [DATA_W-1:0]      new_mag;
    logic [STACK_IDX_W-1:0] push_idx;
    logic [STACK_IDX_W-1:0] pop_idx;
    logic [SYM_IDX_W-1:0]   sym_idx;
    logic [2*SYM_W-1:0]     sym_all;

    // Index of the highest nonzero byte, zero for a zero word.
    function automatic logic [BYTE_IDX_W-1:0] top_byte(input logic [DATA_W-1:0] w);
        logic [BYTE_IDX_W-1:0] t;
        t = '0;
        for (int k = 0; k < NBYTES; k++) begin
            if (w[k*8 +: 8] != 8'd0)
            begin
                t = BYTE_IDX_W'(k);
            end
        end
        return t;
    endfunction

    assign abs_val  = value[DATA_W-1] ? (DATA_W'(0) - value) : value;
    assign div_byte = mag_reg[byte_reg*8 +: 8];

    // Long division of one byte by the radix, one quotient bit per step.
    always_comb
    begin
        logic [RADIX_W-1:0] t;
        part_rem = RADIX_W'(rem_reg);
        quo_byte = '0;
        for (int b = 7; b >= 0; b--) begin
            t = {part_rem[RADIX_W-2:0], div_byte[b]};
            if (t >= radix)
            begin
                quo_byte[b] = 1'b1;
                part_rem    = t - radix;
            end
            else
            begin
                part_rem = t;
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < NBYTES; k++) begin
            new_mag[k*8 +: 8] = (BYTE_IDX_W'(k) == byte_reg) ? quo_byte : mag_reg[k*8 +: 8];
        end
    end

    assign push_idx = cnt_reg[STACK_IDX_W-1:0];
    assign pop_idx  = STACK_IDX_W'(cnt_reg - CNT_W'(1));
    assign sym_idx  = SYM_IDX_W'(stack_reg[pop_idx]);
    assign sym_all  = {symbols_high, symbols_low};

    always_comb
    begin
        mag_next       = mag_reg;
        rem_next       = rem_reg;
        byte_next      = byte_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;

        if (cmd.load)
        begin
            mag_next  = abs_val;
            rem_next  = '0;
            byte_next = top_byte(abs_val);
            neg_next  = value[DATA_W-1];
            cnt_next  = '0;
        end

        if (cmd.div)
        begin
            mag_next = new_mag;
            if (byte_reg == '0)
            begin
                // Digit complete: push it and restart at the top byte.
                cnt_next  = cnt_reg + CNT_W'(1);
                rem_next  = '0;
                byte_next = top_byte(new_mag);
            end
            else
            begin
                rem_next  = part_rem[DIGIT_W-1:0];
                byte_next = byte_reg - BYTE_IDX_W'(1);
            end
        end

        if (cmd.emit_sign)
        begin
            out_valid_next = 1'b1;
            out_data_next  = CH_MINUS;
            out_last_next  = 1'b0;
        end

        if (cmd.emit_digit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = sym_all[sym_idx*CHAR_W +: CHAR_W];
            out_last_next  = (cnt_reg == CNT_W'(1));
            cnt_next       = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        rem_reg      <= rem_next;
        byte_reg     <= byte_next;
        neg_reg      <= neg_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        if (cmd.div && byte_reg == '0)
        begin
            stack_reg[push_idx] <= part_rem[DIGIT_W-1:0];
        end
    end

    assign status.div_final  = (byte_reg == '0) && (new_mag == '0);
    assign status.neg        = neg_reg;
    assign status.last_digit = (cnt_reg == CNT_W'(1));
    assign status.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    `SRTC_ASSERT_HOLDS(a_rem_below_radix, cmd.div, RADIX_W'(rem_reg) < radix, "remainder reached radix")
    `SRTC_ASSERT_HOLDS(a_load_stack_empty, cmd.load, cnt_reg == '0, "new item while digits remain")
    `SRTC_ASSERT_HOLDS(a_emit_into_free, cmd.emit_sign || cmd.emit_digit, !out_valid_reg || m_tready, "emit over a waiting character")
    `SRTC_ASSERT_NEXT(a_more_digits, cmd.div && byte_reg == '0 && !status.div_final, mag_reg != '0, "digit loop continued on zero")

endmodule

`default_nettype wire

### design/signed_radix_text_converter.sv
// Flow: an item is accepted in the idle state; for each digit the divide step works through
// the magnitude one byte per step, from its highest nonzero byte down to byte 0; then the '-'
// and digits leave one per cycle from the output register when not stalled.
// Throughput: one number at a time; a new number is taken only after its last digit has
// entered the output register, and the shared byte-wide divide step bounds the rate.
// Reset: config registers clear (radix 0, so items are dropped), controller idles,
// output register empties.
`default_nettype none

module signed_radix_text_converter #(
    parameter int MAX_RADIX = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [srtc_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [srtc_pkg::PDATA_W-1:0] pwdata,
    output logic      [srtc_pkg::PDATA_W-1:0] prdata,
    output logic                              pready,
    // input stream
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [srtc_pkg::DATA_W-1:0]  s_tdata,   // [31:0] value
    // output stream
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [srtc_pkg::CHAR_W-1:0]  m_tdata,   // [7:0] character
    output logic                              m_tlast
);
    import srtc_pkg::*;

    logic [RADIX_W-1:0] radix;
    logic [SYM_W-1:0]   symbols_low;
    logic [SYM_W-1:0]   symbols_high;
    logic               alpha_ok;
    srtc_cmd_t          cmd;
    srtc_status_t       status;

    // Registers never stall the bus.
    assign pready = 1'b1;

    // Config registers plus the alphabet check, judged as each write lands.
    srtc_cfg #(
        .MAX_RADIX (MAX_RADIX)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .radix        (radix),
        .symbols_low  (symbols_low),
        .symbols_high (symbols_high),
        .alpha_ok     (alpha_ok)
    );

    // Sequencer: take an item, divide out all digits, then send any sign and the digits.
    srtc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .alpha_ok (alpha_ok),
        .status   (status),
        .cmd      (cmd)
    );

    // Magnitude, byte-wide divide step, digit stack and output register.
    srtc_dp #(
        .MAX_RADIX (MAX_RADIX)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .value        (s_tdata),
        .radix        (radix),
        .symbols_low  (symbols_low),
        .symbols_high (symbols_high),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

endmodule

`default_nettype wire

### dv/srtc_text_checker.sv
`timescale 1ns / 1ps

module srtc_text_checker
    import srtc_pkg::*;
#(
    parameter int MAX_RADIX = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    input  logic                pready,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [DATA_W-1:0]   s_tdata,    // [31:0] value
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [CHAR_W-1:0]   m_tdata,    // [7:0] character
    input  logic                m_tlast,
    output int                  fail_count,
    output int                  pending,
    output int                  numbers_seen,
    output int                  numbers_dropped,
    output int                  chars_seen
);

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } text_char_t;

    logic [RADIX_W-1:0] base_reg;
    logic [SYM_W-1:0]   sym_lo_reg;
    logic [SYM_W-1:0]   sym_hi_reg;
    text_char_t         text_q[$];
    int                 fail_n;
    int                 number_n;
    int                 drop_n;
    int                 char_n;

    function automatic logic [CHAR_W-1:0] symbol(input int k);
        logic [SYM_W-1:0] word;
        word = (k < 8) ? sym_lo_reg : sym_hi_reg;
        return word[(k % 8) * CHAR_W +: CHAR_W];
    endfunction

    function automatic bit alphabet_valid();
        logic [CHAR_W-1:0] c;
        if (base_reg < 2 || base_reg > MAX_RADIX)
            return 1'b0;
        for (int i = 0; i < base_reg; i++)
        begin
            c = symbol(i);
            if (c == 8'h00 || c == CH_PLUS || c == CH_MINUS || c == CH_SPACE ||
                (c >= CH_WS_LO && c <= CH_WS_HI))
                return 1'b0;
            for (int j = i + 1; j < base_reg; j++)
                if (symbol(j) == c)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // Queue the text of one number, sign first, most significant digit first.
    function automatic void spell_number(input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] mag;
        logic [CHAR_W-1:0] digit_syms[$];
        if (value[DATA_W-1])
        begin
            mag = -value;   // wraps, so the most negative value stays 2^31
            text_q.push_back('{CH_MINUS, 1'b0});
        end
        else
            mag = value;
        if (mag == 0)
        begin
            text_q.push_back('{symbol(0), 1'b1});
            return;
        end
        while (mag != 0)
        begin
            digit_syms.push_front(symbol(mag % base_reg));
            mag = mag / base_reg;
        end
        foreach (digit_syms[i])
            text_q.push_back('{digit_syms[i], (i == digit_syms.size() - 1) ? 1'b1 : 1'b0});
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        text_char_t want;
        if (!rst_n)
        begin
            base_reg   = '0;
            sym_lo_reg = '0;
            sym_hi_reg = '0;
            text_q.delete();
            fail_n     = 0;
            number_n   = 0;
            drop_n     = 0;
            char_n     = 0;
            fail_count      <= 0;
            pending         <= 0;
            numbers_seen    <= 0;
            numbers_dropped <= 0;
            chars_seen      <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:3])
                    REG_RADIX:        base_reg   = pwdata[RADIX_W-1:0];
                    REG_SYMBOLS_LOW:  sym_lo_reg = pwdata;
                    REG_SYMBOLS_HIGH: sym_hi_reg = pwdata;
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                char_n++;
                if (text_q.size() == 0)
                begin
                    fail_n++;
                    $error("character 0x%02h arrived with no text pending", m_tdata);
                end
                else
                begin
                    want = text_q.pop_front();
                    if (m_tdata !== want.character)
                    begin
                        fail_n++;
                        $error("character: expected 0x%02h, actual 0x%02h",
                               want.character, m_tdata);
                    end
                    if (m_tlast !== want.last)
                    begin
                        fail_n++;
                        $error("last: expected %0b, actual %0b", want.last, m_tlast);
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                number_n++;
                if (alphabet_valid())
                    spell_number(s_tdata);
                else
                    drop_n++;
            end

            fail_count      <= fail_n;
            pending         <= text_q.size();
            numbers_seen    <= number_n;
            numbers_dropped <= drop_n;
            chars_seen      <= char_n;
        end
    end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import srtc_pkg::*;

    // Idle cycles before a register write, long enough for a dropped number
    // or a radix 2 conversion to clear the block.
    localparam int PAUSE        = 200;
    localparam int RANDOM_ITEMS = 120;
    // Past this many random numbers both sides stop idling.
    localparam int CALM_AFTER   = 95;

    // Decimal alphabet; bytes above symbol 9 hold junk the block must ignore.
    localparam logic [SYM_W-1:0] DEC_LO = 64'h3736_3534_3332_3130;
    localparam logic [SYM_W-1:0] DEC_HI = 64'h2B2D_0020_0A2B_3938;
    localparam logic [SYM_W-1:0] HEX_HI = 64'h4645_4443_4241_3938;
    // Binary alphabet "01" with junk in the unused bytes.
    localparam logic [SYM_W-1:0] BIN_LO = 64'hFF2B_2D00_0920_3130;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [ADDR_W-1:0]    paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata  = '0;     // [31:0] value
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [CHAR_W-1:0]    m_tdata;           // [7:0] character
    logic                 m_tlast;

    logic                 calm       = 1'b0;
    int                   ready_hold = 0;
    int                   settings   = 0;
    int                   random_sent = 0;

    int                   fail_count;
    int                   pending;
    int                   numbers_seen;
    int                   numbers_dropped;
    int                   chars_seen;

    always #2 clk = ~clk;

    signed_radix_text_converter #(
        .MAX_RADIX (16)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    srtc_text_checker #(
        .MAX_RADIX (16)
    ) text_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .fail_count      (fail_count),
        .pending         (pending),
        .numbers_seen    (numbers_seen),
        .numbers_dropped (numbers_dropped),
        .chars_seen      (chars_seen)
    );

    // Receiver: alternate ready stretches of random length with stall bursts
    // of random length; hold ready high once the run turns calm.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            ready_hold <= 0;
        end
        else if (calm)
            m_tready <= 1'b1;
        else if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else if (m_tready && $urandom_range(0, 2) == 0)
        begin
            m_tready   <= 1'b0;
            ready_hold <= $urandom_range(0, 12);
        end
        else
        begin
            m_tready   <= 1'b1;
            ready_hold <= $urandom_range(0, 40);
        end
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // One APB write: setup phase, access phase held until pready, then an idle phase so that
    // back-to-back writes never lower and raise psel in the same step.
    task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] word);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Drain the block, then write all three registers. Junk goes into the
    // radix word above its 5 bits.
    task automatic load_alphabet(input logic [RADIX_W-1:0] n,
                                 input logic [SYM_W-1:0] lo,
                                 input logic [SYM_W-1:0] hi);
        logic [PDATA_W-1:0] radix_word;
        radix_word = {$urandom, $urandom};
        radix_word[RADIX_W-1:0] = n;
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (PAUSE) @(posedge clk);
        write_reg(REG_RADIX, radix_word);
        write_reg(REG_SYMBOLS_LOW, lo);
        write_reg(REG_SYMBOLS_HIGH, hi);
        settings++;
    endtask

    // Offer one number; drop valid for a random burst first now and then.
    // Valid stays high after acceptance so the next number follows at once.
    task automatic send_number(input logic [DATA_W-1:0] v);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge clk); while (!s_tready);
    endtask

    function automatic bit usable(input logic [7:0] b);
        return !(b == 8'h00 || b == CH_PLUS || b == CH_MINUS || b == CH_SPACE ||
                 (b >= CH_WS_LO && b <= CH_WS_HI));
    endfunction

    function automatic logic [7:0] forbidden_byte();
        case ($urandom_range(0, 4))
            0:       return 8'h00;
            1:       return CH_PLUS;
            2:       return CH_MINUS;
            3:       return CH_SPACE;
            default: return 8'($urandom_range(CH_WS_LO, CH_WS_HI));
        endcase
    endfunction

    // Mix of full-range words, small magnitudes, extremes and shifted values.
    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2: v = $urandom;
            3, 4:    v = $urandom_range(0, 600) - 300;
            5:
            begin
                case ($urandom_range(0, 4))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = '0;
                    3:       v = '1;
                    default: v = 32'd1;
                endcase
            end
            default:
            begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
        endcase
        return v;
    endfunction

    // Random alphabet of distinct usable bytes, junk above the radix; now and
    // then spoil it so the whole batch is dropped.
    task automatic random_phase();
        logic [2*SYM_W-1:0] syms;
        logic [7:0]         b;
        logic [RADIX_W-1:0] radix_n;
        bit                 spoiled;
        int                 n;
        int                 pos;
        int                 src;
        syms = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(0, 4))
            0:       n = 2;
            1:       n = 16;
            default: n = $urandom_range(3, 15);
        endcase
        for (int k = 0; k < n; k++)
        begin
            bit clash;
            do
            begin
                b = 8'($urandom);
                clash = !usable(b);
                for (int j = 0; j < k; j++)
                    if (syms[j*8 +: 8] == b)
                        clash = 1'b1;
            end
            while (clash);
            syms[k*8 +: 8] = b;
        end
        radix_n = RADIX_W'(n);
        spoiled = ($urandom_range(0, 6) == 0);
        if (spoiled)
        begin
            case ($urandom_range(0, 3))
                0: radix_n = RADIX_W'($urandom_range(0, 1));
                1: radix_n = RADIX_W'($urandom_range(17, 31));
                2:
                begin
                    pos = $urandom_range(0, n - 1);
                    syms[pos*8 +: 8] = forbidden_byte();
                end
                default:
                begin
                    pos = $urandom_range(1, n - 1);
                    src = $urandom_range(0, pos - 1);
                    syms[pos*8 +: 8] = syms[src*8 +: 8];
                end
            endcase
        end
        load_alphabet(radix_n, syms[SYM_W-1:0], syms[2*SYM_W-1:SYM_W]);
        if (spoiled)
            repeat ($urandom_range(1, 3)) send_number(pick_value());
        else
        begin
            repeat ($urandom_range(4, 12))
            begin
                send_number(pick_value());
                random_sent++;
            end
        end
    endtask

    initial
    begin
        logic [DATA_W-1:0]  dec_vals[8] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                            32'h8000_0000, 32'd10, 32'hFFFF_FFF6, 32'd9};
        logic [DATA_W-1:0]  edge_vals[3] = '{32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF};
        int                 bad_pos[7] = '{3, 9, 0, 5, 8, 9, 9};
        logic [7:0]         bad_sym[7] = '{CH_PLUS, CH_MINUS, CH_WS_LO, CH_WS_HI,
                                           CH_SPACE, 8'h00, 8'h31};
        logic [2*SYM_W-1:0] syms;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Out of reset the radix is 0: both numbers must vanish.
        send_number(32'd0);
        send_number(32'h8000_0000);

        // Decimal: zero, one, minus one, both extremes, two-digit values and nine.
        load_alphabet(5'd10, DEC_LO, DEC_HI);
        foreach (dec_vals[i])
            send_number(dec_vals[i]);

        // Smallest radix gives the longest text: 32 digits plus the sign.
        load_alphabet(5'd2, BIN_LO, DEC_HI);
        send_number(32'h8000_0000);
        send_number(32'h7FFF_FFFF);
        send_number(32'd0);

        // Largest radix, every byte of both symbol words in use.
        load_alphabet(5'd16, DEC_LO, HEX_HI);
        foreach (edge_vals[i])
            send_number(edge_vals[i]);

        // Bad alphabets: radix too small, too large, then one forbidden or
        // repeated symbol each. Every number here must be dropped.
        load_alphabet(5'd1, DEC_LO, DEC_HI);
        send_number(32'd5);
        load_alphabet(5'd31, DEC_LO, DEC_HI);
        send_number(32'hFFFF_FFFB);
        foreach (bad_pos[i])
        begin
            syms = {DEC_HI, DEC_LO};
            syms[bad_pos[i]*8 +: 8] = bad_sym[i];
            load_alphabet(5'd10, syms[SYM_W-1:0], syms[2*SYM_W-1:SYM_W]);
            send_number(32'd42);
        end

        // Random alphabets and numbers; go calm for the tail.
        while (random_sent < RANDOM_ITEMS)
        begin
            calm <= (random_sent >= CALM_AFTER);
            random_phase();
        end

        // Drain whatever is still in flight.
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (PAUSE) @(posedge clk);

        $display("Sent %0d numbers over %0d register settings, %0d dropped on bad alphabets;",
                 numbers_seen, settings, numbers_dropped);
        $display("checked %0d characters, radix 2 to 16, sign and zero cases included.",
                 chars_seen);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### files.f
+incdir+design
design/srtc_pkg.sv
design/srtc_cfg.sv
design/srtc_ctrl.sv
design/srtc_dp.sv
design/signed_radix_text_converter.sv
dv/srtc_text_checker.sv
dv/tb_top.sv
